FILE: src/c8_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package c8_pkg;

	localparam int unsigned MEM_BYTES         = 4096;
	localparam int unsigned AW                = 12;
	localparam int unsigned PROGRAM_START_DEF = 512;
	localparam int unsigned STACK_DEPTH_DEF   = 16;
	localparam int unsigned REG_COUNT         = 16;
	localparam int unsigned FRAME_BYTES       = 256;
	localparam int unsigned FONT_BYTES        = 80;

	localparam logic [7:0] FONT [FONT_BYTES] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

	typedef enum logic [1:0] {
		FN_EXEC = 2'd0,
		FN_TICK = 2'd1,
		FN_MWR  = 2'd2,
		FN_FRD  = 2'd3
	} func_t;

	localparam logic [3:0] OP_SYS    = 4'h0;
	localparam logic [3:0] OP_JP     = 4'h1;
	localparam logic [3:0] OP_CALL   = 4'h2;
	localparam logic [3:0] OP_SE_I   = 4'h3;
	localparam logic [3:0] OP_SNE_I  = 4'h4;
	localparam logic [3:0] OP_SE_R   = 4'h5;
	localparam logic [3:0] OP_LD_I   = 4'h6;
	localparam logic [3:0] OP_ADD_I  = 4'h7;
	localparam logic [3:0] OP_ALU    = 4'h8;
	localparam logic [3:0] OP_SNE_R  = 4'h9;
	localparam logic [3:0] OP_LD_IDX = 4'hA;
	localparam logic [3:0] OP_JP_V0  = 4'hB;
	localparam logic [3:0] OP_RND    = 4'hC;
	localparam logic [3:0] OP_DRW    = 4'hD;
	localparam logic [3:0] OP_KEY    = 4'hE;
	localparam logic [3:0] OP_MISC   = 4'hF;

	localparam logic [15:0] INS_CLS = 16'h00E0;
	localparam logic [15:0] INS_RET = 16'h00EE;

	localparam logic [3:0] A_MOV  = 4'h0;
	localparam logic [3:0] A_OR   = 4'h1;
	localparam logic [3:0] A_AND  = 4'h2;
	localparam logic [3:0] A_XOR  = 4'h3;
	localparam logic [3:0] A_ADD  = 4'h4;
	localparam logic [3:0] A_SUB  = 4'h5;
	localparam logic [3:0] A_SHR  = 4'h6;
	localparam logic [3:0] A_SUBN = 4'h7;
	localparam logic [3:0] A_SHL  = 4'hE;

	localparam logic [7:0] K_SKP  = 8'h9E;
	localparam logic [7:0] K_SKNP = 8'hA1;

	localparam logic [7:0] F_GDT  = 8'h07;
	localparam logic [7:0] F_WKEY = 8'h0A;
	localparam logic [7:0] F_SDT  = 8'h15;
	localparam logic [7:0] F_SST  = 8'h18;
	localparam logic [7:0] F_ADDI = 8'h1E;
	localparam logic [7:0] F_FONT = 8'h29;
	localparam logic [7:0] F_BCD  = 8'h33;
	localparam logic [7:0] F_STR  = 8'h55;
	localparam logic [7:0] F_LDR  = 8'h65;

	typedef enum logic [2:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_OR,
		ALU_AND,
		ALU_XOR,
		ALU_SHR,
		ALU_SHL,
		ALU_PASS
	} alu_op_t;

	typedef struct packed {
		logic [15:0] y;
		logic        flag;
	} alu_res_t;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_MISC, S_FRD,
		S_F0, S_F1, S_F2, S_F3, S_EX,
		S_BCD, S_ST, S_LD0, S_LD1,
		S_D0, S_D1, S_D2, S_D3, S_D4,
		S_DONE
	} st_t;

endpackage
`default_nettype wire

FILE: src/c8_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface c8_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [15:0] keys_down;
	logic [7:0]  random_byte;
	logic [11:0] address;
	logic [7:0]  write_data;

	modport source (output valid, func, keys_down, random_byte, address, write_data,
		input ready);
	modport sink (input valid, func, keys_down, random_byte, address, write_data,
		output ready);
endinterface
`default_nettype wire

FILE: src/c8_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface c8_rsp_if;
	logic        valid;
	logic        ready;
	logic [11:0] program_counter;
	logic [15:0] instruction;
	logic [7:0]  read_data;
	logic        screen_changed;
	logic        sound_on;
	logic        waiting_key;
	logic        fault;

	modport source (output valid, program_counter, instruction, read_data,
		screen_changed, sound_on, waiting_key, fault, input ready);
	modport sink (input valid, program_counter, instruction, read_data,
		screen_changed, sound_on, waiting_key, fault, output ready);
endinterface
`default_nettype wire

FILE: src/c8_alu.sv
`timescale 1ns / 1ps
`default_nettype none
module c8_alu (
	input  c8_pkg::alu_op_t  op,
	input  logic [15:0]      a,
	input  logic [15:0]      b,
	output c8_pkg::alu_res_t res
);
	always_comb begin
		res.y    = 16'd0;
		res.flag = 1'b0;
		case (op)
			c8_pkg::ALU_ADD: begin
				res.y    = a + b;
				res.flag = res.y[8];
			end
			c8_pkg::ALU_SUB: begin
				res.y    = a - b;
				res.flag = (a[7:0] >= b[7:0]);
			end
			c8_pkg::ALU_OR:  res.y = a | b;
			c8_pkg::ALU_AND: res.y = a & b;
			c8_pkg::ALU_XOR: res.y = a ^ b;
			c8_pkg::ALU_SHR: begin
				res.y    = {1'b0, a[15:1]};
				res.flag = a[0];
			end
			c8_pkg::ALU_SHL: begin
				res.y    = {a[14:0], 1'b0};
				res.flag = a[7];
			end
			c8_pkg::ALU_PASS: res.y = b;
			default: res.y = 16'd0;
		endcase
	end
endmodule
`default_nettype wire

FILE: src/c8_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module c8_mem (
	input  logic                  clk,
	input  logic                  we,
	input  logic [c8_pkg::AW-1:0] waddr,
	input  logic [7:0]            wdata,
	input  logic [c8_pkg::AW-1:0] raddr,
	output logic [7:0]            rdata
);
	logic [7:0] mem [c8_pkg::MEM_BYTES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: src/chip8_interpreter_core_top.sv
`timescale 1ns / 1ps
`default_nettype none
// CHIP-8 core run by a small sequencer around one shared adder/ALU and a 4 KB memory
// with one write port and one registered read port. After reset the 80 font bytes are
// copied into memory, during which no item is taken. Timer tick and memory write pass
// through S_MISC, a frame byte read also through S_FRD. An instruction goes through
// fetch, two register reads, execute and result, plus states S_D0 to S_D4 per sprite row
// for DXYN, a memory write per register for FX55, a read and a load per register for
// FX65 and a write per digit for FX33. The result sits in an output register; the core
// is busy from the accepted item until its result is loaded there.
module chip8_interpreter_core_top #(
	parameter int unsigned PROGRAM_START = c8_pkg::PROGRAM_START_DEF,
	parameter int unsigned STACK_DEPTH   = c8_pkg::STACK_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	c8_req_if.sink   req,
	c8_rsp_if.source rsp
);
	localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned SIW = $clog2(STACK_DEPTH);

	c8_pkg::st_t state_q, state_d;

	logic [6:0]  init_cnt_q;
	logic [1:0]  fn_q;
	logic [15:0] keys_q;
	logic [7:0]  rnd_q;
	logic [11:0] addr_q;
	logic [7:0]  wd_q;

	logic [11:0] pc_q, next_q;
	logic [15:0] i_q, ins_q;
	logic [7:0]  v_q [c8_pkg::REG_COUNT];
	logic [11:0] stk_q [STACK_DEPTH];
	logic [SPW-1:0] sp_q, sp_m1;
	logic [7:0]  dt_q, st_q, a_q, b_q, line_q, fd0_q, fd1_q, rdata_q;
	logic [3:0]  cnt_q;
	logic [4:0]  row_q;
	logic        chg_q, wait_q, flt_q, hit_q;

	logic        ov_q;
	logic [11:0] o_pc_q;
	logic [15:0] o_ins_q;
	logic [7:0]  o_rd_q;
	logic        o_chg_q, o_snd_q, o_wait_q, o_flt_q;

	logic [7:0]  fr_mem [c8_pkg::FRAME_BYTES];
	logic [c8_pkg::FRAME_BYTES-1:0] nz_q;
	logic [7:0]  fr_rd_q, frd_eff;
	logic        fr_nz_q;
	logic        fr_re, fr_we, fr_clr;
	logic [7:0]  fr_raddr, fr_waddr, fr_wdata;

	logic        mem_we;
	logic [11:0] mem_waddr, mem_raddr;
	logic [7:0]  mem_wdata, mem_rdata;

	c8_pkg::alu_op_t  alu_op;
	logic [15:0]      alu_a, alu_b;
	c8_pkg::alu_res_t alu_r;

	logic [3:0]  v_ridx;
	logic [7:0]  v_rd;
	logic [11:0] stk_rd;
	logic [7:0]  p_hi, p_lo;
	logic [3:0]  x, y, n;
	logic [7:0]  nn;
	logic        held, leave;
	logic [2:0]  col0, col1;

	function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [3:0] sel);
		logic [7:0] h, r, t;
		begin
			if (v >= 8'd200) begin
				h = 8'd2;
				r = v - 8'd200;
			end else if (v >= 8'd100) begin
				h = 8'd1;
				r = v - 8'd100;
			end else begin
				h = 8'd0;
				r = v;
			end
			t = 8'd0;
			for (int k = 1; k < 10; k++) begin
				if (r >= 8'(k * 10)) t = 8'(k);
			end
			case (sel)
				4'd0:    bcd_digit = h;
				4'd1:    bcd_digit = t;
				default: bcd_digit = 8'(r - 8'(t * 8'd10));
			endcase
		end
	endfunction

	function automatic logic [3:0] low_key(input logic [15:0] k);
		logic [3:0] idx;
		begin
			idx = 4'd0;
			for (int j = 15; j >= 0; j--) begin
				if (k[j]) idx = 4'(j);
			end
			low_key = idx;
		end
	endfunction

	c8_alu u_alu (.op(alu_op), .a(alu_a), .b(alu_b), .res(alu_r));

	c8_mem u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);

	assign x      = ins_q[11:8];
	assign y      = ins_q[7:4];
	assign n      = ins_q[3:0];
	assign nn     = ins_q[7:0];
	assign v_rd   = v_q[v_ridx];
	assign sp_m1  = sp_q - 1'b1;
	assign stk_rd = stk_q[sp_m1[SIW-1:0]];
	assign held   = keys_q[a_q[3:0]];
	assign {p_hi, p_lo} = {line_q, 8'h00} >> a_q[2:0];
	assign col0   = a_q[5:3];
	assign col1   = a_q[5:3] + 3'd1;
	assign frd_eff = fr_nz_q ? fr_rd_q : 8'h00;
	assign leave  = !ov_q || rsp.ready;

	assign req.ready = (state_q == c8_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= c8_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		alu_op    = c8_pkg::ALU_ADD;
		alu_a     = i_q;
		alu_b     = {12'd0, cnt_q};
		mem_we    = 1'b0;
		mem_waddr = alu_r.y[11:0];
		mem_wdata = v_rd;
		mem_raddr = alu_r.y[11:0];
		fr_re     = 1'b0;
		fr_raddr  = {row_q, col0};
		fr_we     = 1'b0;
		fr_waddr  = {row_q, col0};
		fr_wdata  = fd0_q ^ p_hi;
		fr_clr    = 1'b0;
		v_ridx    = cnt_q;
		case (state_q)
			c8_pkg::S_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = {5'd0, init_cnt_q};
				mem_wdata = c8_pkg::FONT[init_cnt_q];
				if (init_cnt_q == 7'(c8_pkg::FONT_BYTES - 1)) state_d = c8_pkg::S_IDLE;
			end
			c8_pkg::S_IDLE: begin
				if (req.valid) begin
					state_d = (req.func == c8_pkg::FN_EXEC) ? c8_pkg::S_F0 : c8_pkg::S_MISC;
				end
			end
			c8_pkg::S_MISC: begin
				state_d = c8_pkg::S_DONE;
				case (fn_q)
					c8_pkg::FN_MWR: begin
						mem_we    = 1'b1;
						mem_waddr = addr_q;
						mem_wdata = wd_q;
					end
					c8_pkg::FN_FRD: begin
						fr_re    = 1'b1;
						fr_raddr = addr_q[7:0];
						state_d  = c8_pkg::S_FRD;
					end
					default: ;
				endcase
			end
			c8_pkg::S_FRD: state_d = c8_pkg::S_DONE;
			c8_pkg::S_F0: begin
				mem_raddr = pc_q;
				state_d   = c8_pkg::S_F1;
			end
			c8_pkg::S_F1: begin
				alu_a   = {4'd0, pc_q};
				alu_b   = 16'd1;
				state_d = c8_pkg::S_F2;
			end
			c8_pkg::S_F2: begin
				alu_a   = {4'd0, pc_q};
				alu_b   = 16'd2;
				v_ridx  = x;
				state_d = c8_pkg::S_F3;
			end
			c8_pkg::S_F3: begin
				v_ridx  = y;
				state_d = c8_pkg::S_EX;
			end
			c8_pkg::S_EX: begin
				state_d = c8_pkg::S_DONE;
				v_ridx  = 4'd0;
				alu_a   = {4'd0, next_q};
				alu_b   = 16'd2;
				case (ins_q[15:12])
					c8_pkg::OP_SYS: alu_a = {4'd0, stk_rd};
					c8_pkg::OP_ADD_I: begin
						alu_a = {8'd0, a_q};
						alu_b = {8'd0, nn};
					end
					c8_pkg::OP_ALU: begin
						alu_a = {8'd0, a_q};
						alu_b = {8'd0, b_q};
						case (n)
							c8_pkg::A_MOV: alu_op = c8_pkg::ALU_PASS;
							c8_pkg::A_OR:  alu_op = c8_pkg::ALU_OR;
							c8_pkg::A_AND: alu_op = c8_pkg::ALU_AND;
							c8_pkg::A_XOR: alu_op = c8_pkg::ALU_XOR;
							c8_pkg::A_SUB: alu_op = c8_pkg::ALU_SUB;
							c8_pkg::A_SHR: alu_op = c8_pkg::ALU_SHR;
							c8_pkg::A_SHL: alu_op = c8_pkg::ALU_SHL;
							c8_pkg::A_SUBN: begin
								alu_op = c8_pkg::ALU_SUB;
								alu_a  = {8'd0, b_q};
								alu_b  = {8'd0, a_q};
							end
							default: alu_op = c8_pkg::ALU_ADD;
						endcase
					end
					c8_pkg::OP_JP_V0: begin
						alu_a = {4'd0, ins_q[11:0]};
						alu_b = {8'd0, v_rd};
					end
					c8_pkg::OP_DRW: begin
						if (n != 4'd0) state_d = c8_pkg::S_D0;
					end
					c8_pkg::OP_MISC: begin
						case (nn)
							c8_pkg::F_ADDI: begin
								alu_a = i_q;
								alu_b = {8'd0, a_q};
							end
							c8_pkg::F_FONT: begin
								alu_a = {10'd0, a_q[3:0], 2'd0};
								alu_b = {12'd0, a_q[3:0]};
							end
							c8_pkg::F_BCD: state_d = c8_pkg::S_BCD;
							c8_pkg::F_STR: state_d = c8_pkg::S_ST;
							c8_pkg::F_LDR: state_d = c8_pkg::S_LD0;
							default: ;
						endcase
					end
					default: ;
				endcase
			end
			c8_pkg::S_BCD: begin
				mem_we    = 1'b1;
				mem_wdata = bcd_digit(a_q, cnt_q);
				if (cnt_q == 4'd2) state_d = c8_pkg::S_DONE;
			end
			c8_pkg::S_ST: begin
				mem_we = 1'b1;
				if (cnt_q == x) state_d = c8_pkg::S_DONE;
			end
			c8_pkg::S_LD0: state_d = c8_pkg::S_LD1;
			c8_pkg::S_LD1: state_d = (cnt_q == x) ? c8_pkg::S_DONE : c8_pkg::S_LD0;
			c8_pkg::S_D0: state_d = c8_pkg::S_D1;
			c8_pkg::S_D1: begin
				alu_a    = {8'd0, b_q};
				fr_re    = 1'b1;
				fr_raddr = {alu_r.y[4:0], col0};
				state_d  = c8_pkg::S_D2;
			end
			c8_pkg::S_D2: begin
				fr_re    = 1'b1;
				fr_raddr = {row_q, col1};
				state_d  = c8_pkg::S_D3;
			end
			c8_pkg::S_D3: begin
				fr_we   = 1'b1;
				state_d = c8_pkg::S_D4;
			end
			c8_pkg::S_D4: begin
				fr_we    = 1'b1;
				fr_waddr = {row_q, col1};
				fr_wdata = fd1_q ^ p_lo;
				state_d  = (cnt_q == n - 4'd1) ? c8_pkg::S_DONE : c8_pkg::S_D0;
			end
			c8_pkg::S_DONE: begin
				if (leave) state_d = c8_pkg::S_IDLE;
			end
			default: state_d = c8_pkg::S_IDLE;
		endcase
		if (state_q == c8_pkg::S_EX && ins_q == c8_pkg::INS_CLS) fr_clr = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (fr_re) begin
			fr_rd_q <= fr_mem[fr_raddr];
			fr_nz_q <= nz_q[fr_raddr];
		end
		if (fr_we) begin
			fr_mem[fr_waddr] <= fr_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nz_q <= '0;
		end else if (fr_clr) begin
			nz_q <= '0;
		end else if (fr_we) begin
			nz_q[fr_waddr] <= (fr_wdata != 8'h00);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == c8_pkg::S_EX && ins_q[15:12] == c8_pkg::OP_CALL
				&& sp_q < SPW'(STACK_DEPTH)) begin
			stk_q[sp_q[SIW-1:0]] <= pc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_cnt_q <= '0;
			pc_q       <= PROGRAM_START[11:0];
			i_q        <= '0;
			sp_q       <= '0;
			dt_q       <= '0;
			st_q       <= '0;
			for (int r = 0; r < c8_pkg::REG_COUNT; r++) v_q[r] <= '0;
		end else begin
			case (state_q)
				c8_pkg::S_INIT: init_cnt_q <= init_cnt_q + 7'd1;
				c8_pkg::S_MISC: begin
					if (fn_q == c8_pkg::FN_TICK) begin
						if (dt_q != 8'd0) dt_q <= dt_q - 8'd1;
						if (st_q != 8'd0) st_q <= st_q - 8'd1;
					end
				end
				c8_pkg::S_EX: begin
					case (ins_q[15:12])
						c8_pkg::OP_SYS: begin
							if (ins_q == c8_pkg::INS_RET && sp_q != '0) sp_q <= sp_m1;
						end
						c8_pkg::OP_CALL: begin
							if (sp_q < SPW'(STACK_DEPTH)) sp_q <= sp_q + 1'b1;
						end
						c8_pkg::OP_LD_I:  v_q[x] <= nn;
						c8_pkg::OP_ADD_I: v_q[x] <= alu_r.y[7:0];
						c8_pkg::OP_ALU: begin
							case (n)
								c8_pkg::A_MOV, c8_pkg::A_OR, c8_pkg::A_AND,
								c8_pkg::A_XOR: v_q[x] <= alu_r.y[7:0];
								c8_pkg::A_ADD, c8_pkg::A_SUB, c8_pkg::A_SHR,
								c8_pkg::A_SUBN, c8_pkg::A_SHL: begin
									v_q[x]  <= alu_r.y[7:0];
									v_q[15] <= {7'd0, alu_r.flag};
								end
								default: ;
							endcase
						end
						c8_pkg::OP_LD_IDX: i_q <= {4'd0, ins_q[11:0]};
						c8_pkg::OP_RND:    v_q[x] <= rnd_q & nn;
						c8_pkg::OP_DRW: begin
							if (n == 4'd0) v_q[15] <= 8'd0;
						end
						c8_pkg::OP_MISC: begin
							case (nn)
								c8_pkg::F_GDT: v_q[x] <= dt_q;
								c8_pkg::F_WKEY: begin
									if (keys_q != 16'd0) v_q[x] <= {4'd0, low_key(keys_q)};
								end
								c8_pkg::F_SDT:  dt_q <= a_q;
								c8_pkg::F_SST:  st_q <= a_q;
								c8_pkg::F_ADDI, c8_pkg::F_FONT: i_q <= alu_r.y;
								default: ;
							endcase
						end
						default: ;
					endcase
				end
				c8_pkg::S_LD1: v_q[cnt_q] <= mem_rdata;
				c8_pkg::S_D4: begin
					if (cnt_q == n - 4'd1) v_q[15] <= {7'd0, hit_q | (|(fd1_q & p_lo))};
				end
				c8_pkg::S_DONE: begin
					if (leave) pc_q <= next_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			c8_pkg::S_IDLE: begin
				fn_q    <= req.func;
				keys_q  <= req.keys_down;
				rnd_q   <= req.random_byte;
				addr_q  <= req.address;
				wd_q    <= req.write_data;
				ins_q   <= '0;
				next_q  <= pc_q;
				rdata_q <= '0;
				chg_q   <= 1'b0;
				wait_q  <= 1'b0;
				flt_q   <= 1'b0;
				hit_q   <= 1'b0;
			end
			c8_pkg::S_FRD: rdata_q <= (addr_q[11:8] == 4'd0) ? frd_eff : 8'h00;
			c8_pkg::S_F1:  ins_q[15:8] <= mem_rdata;
			c8_pkg::S_F2: begin
				ins_q[7:0] <= mem_rdata;
				next_q     <= alu_r.y[11:0];
				a_q        <= v_rd;
			end
			c8_pkg::S_F3: b_q <= v_rd;
			c8_pkg::S_EX: begin
				cnt_q <= '0;
				case (ins_q[15:12])
					c8_pkg::OP_SYS: begin
						if (ins_q == c8_pkg::INS_CLS) chg_q <= |nz_q;
						else if (ins_q == c8_pkg::INS_RET) begin
							if (sp_q == '0) flt_q <= 1'b1;
							else next_q <= alu_r.y[11:0];
						end
					end
					c8_pkg::OP_JP: next_q <= ins_q[11:0];
					c8_pkg::OP_CALL: begin
						if (sp_q >= SPW'(STACK_DEPTH)) flt_q <= 1'b1;
						else next_q <= ins_q[11:0];
					end
					c8_pkg::OP_SE_I:  if (a_q == nn) next_q <= alu_r.y[11:0];
					c8_pkg::OP_SNE_I: if (a_q != nn) next_q <= alu_r.y[11:0];
					c8_pkg::OP_SE_R: begin
						if (n == 4'd0 && a_q == b_q) next_q <= alu_r.y[11:0];
					end
					c8_pkg::OP_SNE_R: begin
						if (n == 4'd0 && a_q != b_q) next_q <= alu_r.y[11:0];
					end
					c8_pkg::OP_JP_V0: next_q <= alu_r.y[11:0];
					c8_pkg::OP_KEY: begin
						if ((nn == c8_pkg::K_SKP && held) || (nn == c8_pkg::K_SKNP && !held))
							next_q <= alu_r.y[11:0];
					end
					c8_pkg::OP_MISC: begin
						if (nn == c8_pkg::F_WKEY && keys_q == 16'd0) begin
							wait_q <= 1'b1;
							next_q <= pc_q;
						end
					end
					default: ;
				endcase
			end
			c8_pkg::S_BCD, c8_pkg::S_ST, c8_pkg::S_LD1: cnt_q <= cnt_q + 4'd1;
			c8_pkg::S_D1: begin
				line_q <= mem_rdata;
				row_q  <= alu_r.y[4:0];
			end
			c8_pkg::S_D2: fd0_q <= frd_eff;
			c8_pkg::S_D3: begin
				fd1_q <= frd_eff;
				hit_q <= hit_q | (|(fd0_q & p_hi));
			end
			c8_pkg::S_D4: begin
				hit_q <= hit_q | (|(fd1_q & p_lo));
				chg_q <= chg_q | (line_q != 8'h00);
				cnt_q <= cnt_q + 4'd1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (state_q == c8_pkg::S_DONE && leave) begin
			ov_q <= 1'b1;
		end else if (rsp.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == c8_pkg::S_DONE && leave) begin
			o_pc_q   <= next_q;
			o_ins_q  <= ins_q;
			o_rd_q   <= rdata_q;
			o_chg_q  <= chg_q;
			o_snd_q  <= (st_q != 8'd0);
			o_wait_q <= wait_q;
			o_flt_q  <= flt_q;
		end
	end

	assign rsp.valid           = ov_q;
	assign rsp.program_counter = o_pc_q;
	assign rsp.instruction     = o_ins_q;
	assign rsp.read_data       = o_rd_q;
	assign rsp.screen_changed  = o_chg_q;
	assign rsp.sound_on        = o_snd_q;
	assign rsp.waiting_key     = o_wait_q;
	assign rsp.fault           = o_flt_q;
endmodule
`default_nettype wire

FILE: src/c8_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module c8_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [15:0] rsp_instruction,
	input logic        rsp_screen_changed,
	input logic        rsp_waiting_key,
	input logic        rsp_fault
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready right after an accepted item");

	a_wait_op: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_waiting_key |->
		rsp_instruction[15:12] == c8_pkg::OP_MISC && rsp_instruction[7:0] == c8_pkg::F_WKEY)
		else $error("waiting_key on a non key-wait opcode");

	a_fault_op: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_fault |->
		rsp_instruction == c8_pkg::INS_RET || rsp_instruction[15:12] == c8_pkg::OP_CALL)
		else $error("fault on an opcode without stack access");

	a_chg_op: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_screen_changed |->
		rsp_instruction == c8_pkg::INS_CLS || rsp_instruction[15:12] == c8_pkg::OP_DRW)
		else $error("screen_changed on an opcode that leaves the frame");
endmodule

bind chip8_interpreter_core_top c8_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_instruction(rsp.instruction),
	.rsp_screen_changed(rsp.screen_changed),
	.rsp_waiting_key(rsp.waiting_key),
	.rsp_fault(rsp.fault)
);
`default_nettype wire
